FILE: rtl/ttt_pkg.sv
// shared types and constants for the tcp time-wait / retransmit timer table
// no dependencies
package ttt_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int ADDR_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_W      = 4;
    localparam int TW_W        = 16;
    localparam int RT_REM_W    = 16;
    localparam int RT_BASE_W   = 12;
    localparam int RETRY_W     = 2;

    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int EVQ_DEPTH   = 8;
    localparam int EVQ_PTR_W   = $clog2(EVQ_DEPTH);
    localparam int EVQ_CNT_W   = $clog2(EVQ_DEPTH + 1);

    localparam logic [TW_W-1:0]      TW_TICKS_RST  = TW_W'(60);
    localparam logic [RT_BASE_W-1:0] RT_BASE_RST   = RT_BASE_W'(2);
    localparam logic [RETRY_W-1:0]   MAX_RETRY_RST = RETRY_W'(3);

    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_ARM_TW    = 2'd1,
        REQ_ARM_RT    = 2'd2,
        REQ_CANCEL_RT = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        EV_END     = 2'd0,
        EV_RELEASE = 2'd1,
        EV_CLOSE   = 2'd2,
        EV_RESEND  = 2'd3
    } t_ev_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEWAIT  = 2'd0,
        CFG_RT_BASE   = 2'd1,
        CFG_MAX_RETRY = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [TW_W-1:0]      tw_ticks;
        logic [RT_BASE_W-1:0] rt_base;
        logic [RETRY_W-1:0]   max_retry;
    } t_cfg;

    typedef struct packed {
        logic            act;
        logic [TW_W-1:0] rem;
    } t_tw_ent;

    typedef struct packed {
        logic                act;
        logic [RT_REM_W-1:0] rem;
        logic [RETRY_W-1:0]  retries;
    } t_rt_ent;

    typedef struct packed {
        t_ev_kind          kind;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_event;

    // up to two items per cycle, second one only lands after the first
    typedef struct packed {
        logic   v0;
        t_event e0;
        logic   v1;
        t_event e1;
    } t_evq_push;

endpackage

FILE: rtl/ttt_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module ttt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

FILE: rtl/ttt_upd.sv
// per-slot timer update: count down both timers of one entry, flag expiries
// depends on ttt_pkg
module ttt_upd
    import ttt_pkg::*;
(
    input  t_tw_ent i_tw,
    input  t_rt_ent i_rt,
    input  t_cfg    i_cfg,
    output t_tw_ent o_tw,
    output t_rt_ent o_rt,
    output logic    o_release,
    output logic    o_rt_event,
    output logic    o_close
);

    logic tw_exp;
    logic rt_exp;

    always_comb begin
        tw_exp = i_tw.act && (i_tw.rem <= TW_W'(1));
        rt_exp = i_rt.act && (i_rt.rem <= RT_REM_W'(1));

        o_tw = i_tw;
        if (tw_exp) begin
            o_tw = '0;
        end else if (i_tw.act) begin
            o_tw.rem = i_tw.rem - TW_W'(1);
        end

        o_close    = rt_exp && (i_rt.retries >= i_cfg.max_retry);
        o_rt_event = rt_exp;
        o_release  = tw_exp;

        o_rt = i_rt;
        if (rt_exp) begin
            if (o_close) begin
                o_rt.act = 1'b0;
                o_rt.rem = '0;
            end else begin
                // backoff: base doubled once per retry already made
                o_rt.rem     = RT_REM_W'(i_cfg.rt_base) << i_rt.retries;
                o_rt.retries = i_rt.retries + RETRY_W'(1);
            end
        end else if (i_rt.act) begin
            o_rt.rem = i_rt.rem - RT_REM_W'(1);
        end
    end

endmodule

FILE: rtl/ttt_evq.sv
// event queue between the slot scan and the output stream
// depends on ttt_pkg
module ttt_evq
    import ttt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_evq_push            i_push,
    output logic [EVQ_CNT_W-1:0] o_count,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_event               o_event
);

    t_event               r_mem [EVQ_DEPTH];
    logic [EVQ_PTR_W-1:0] r_wp;
    logic [EVQ_PTR_W-1:0] r_rp;
    logic [EVQ_CNT_W-1:0] r_count;
    logic [EVQ_PTR_W-1:0] wa1;
    logic                 pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_event = r_mem[r_rp];
    assign o_count = r_count;
    assign wa1     = r_wp + EVQ_PTR_W'(i_push.v0);

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wp] <= i_push.e0;
        end
        if (i_push.v1) begin
            r_mem[wa1] <= i_push.e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + EVQ_PTR_W'(i_push.v0) + EVQ_PTR_W'(i_push.v1);
            r_rp    <= r_rp + EVQ_PTR_W'(pop);
            r_count <= r_count + EVQ_CNT_W'(i_push.v0) + EVQ_CNT_W'(i_push.v1)
                       - EVQ_CNT_W'(pop);
        end
    end

endmodule

FILE: rtl/ttt_ctrl.sv
// request handling and slot scan: owns the two timer memories and their
// read-modify-write pipeline; depends on ttt_pkg, ttt_ram, ttt_upd
module ttt_ctrl
    import ttt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  t_req                 i_req,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic [EVQ_CNT_W-1:0] i_evq_count,
    output t_evq_push            o_push
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state                r_state;
    logic [ADDR_W-1:0]     r_scan;
    logic                  r_pend;
    logic [ADDR_W-1:0]     r_pend_addr;
    logic                  r_pend_twv;
    logic                  r_pend_rtv;
    logic [NUM_SLOTS-1:0]  r_tw_vld;
    logic [NUM_SLOTS-1:0]  r_rt_vld;

    logic                  tw_we;
    logic                  rt_we;
    logic [ADDR_W-1:0]     wr_addr;
    t_tw_ent               tw_wdata;
    t_rt_ent               rt_wdata;
    logic [$bits(t_tw_ent)-1:0] tw_rdata;
    logic [$bits(t_rt_ent)-1:0] rt_rdata;
    t_tw_ent               tw_cur;
    t_rt_ent               rt_cur;
    t_tw_ent               tw_nxt;
    t_rt_ent               rt_nxt;
    logic                  rel;
    logic                  rt_ev;
    logic                  close;
    logic                  req_acc;
    logic                  req_ok;
    logic                  issue;
    logic                  push_end;

    ttt_ram #(.DEPTH(NUM_SLOTS), .WIDTH($bits(t_tw_ent))) u_tw_ram (
        .i_clk   (i_clk),
        .i_we    (tw_we),
        .i_waddr (wr_addr),
        .i_wdata (tw_wdata),
        .i_raddr (r_scan),
        .o_rdata (tw_rdata)
    );

    ttt_ram #(.DEPTH(NUM_SLOTS), .WIDTH($bits(t_rt_ent))) u_rt_ram (
        .i_clk   (i_clk),
        .i_we    (rt_we),
        .i_waddr (wr_addr),
        .i_wdata (rt_wdata),
        .i_raddr (r_scan),
        .o_rdata (rt_rdata)
    );

    // entries never written read as idle timers
    assign tw_cur = r_pend_twv ? t_tw_ent'(tw_rdata) : '0;
    assign rt_cur = r_pend_rtv ? t_rt_ent'(rt_rdata) : '0;

    ttt_upd u_upd (
        .i_tw       (tw_cur),
        .i_rt       (rt_cur),
        .i_cfg      (i_cfg),
        .o_tw       (tw_nxt),
        .o_rt       (rt_nxt),
        .o_release  (rel),
        .o_rt_event (rt_ev),
        .o_close    (close)
    );

    assign o_req_ready = (r_state == S_IDLE);
    assign req_acc     = i_req_valid && o_req_ready;
    assign req_ok      = req_acc && (i_req != REQ_TICK) && (int'(i_slot) < NUM_SLOTS);

    // a read may only go out if both it and the one in flight fit in the queue
    assign issue    = (r_state == S_SCAN)
                      && (int'(i_evq_count) + (r_pend ? 2 : 0) <= EVQ_DEPTH - 2);
    assign push_end = (r_state == S_FLUSH) && !r_pend
                      && (int'(i_evq_count) <= EVQ_DEPTH - 1);

    always_comb begin
        tw_we    = 1'b0;
        rt_we    = 1'b0;
        wr_addr  = r_pend_addr;
        tw_wdata = tw_nxt;
        rt_wdata = rt_nxt;
        o_push   = '0;

        if (r_pend) begin
            tw_we          = 1'b1;
            rt_we          = 1'b1;
            o_push.v0      = rel;
            o_push.e0.kind = EV_RELEASE;
            o_push.e0.slot = SLOT_W'(r_pend_addr);
            o_push.e0.last = 1'b0;
            o_push.v1      = rt_ev;
            o_push.e1.kind = close ? EV_CLOSE : EV_RESEND;
            o_push.e1.slot = SLOT_W'(r_pend_addr);
            o_push.e1.last = 1'b0;
        end else if (req_ok) begin
            wr_addr = i_slot[ADDR_W-1:0];
            unique case (i_req)
                REQ_ARM_TW: begin
                    tw_we        = 1'b1;
                    tw_wdata.act = 1'b1;
                    tw_wdata.rem = i_cfg.tw_ticks;
                end
                REQ_ARM_RT: begin
                    rt_we            = 1'b1;
                    rt_wdata.act     = 1'b1;
                    rt_wdata.rem     = RT_REM_W'(i_cfg.rt_base);
                    rt_wdata.retries = '0;
                end
                REQ_CANCEL_RT: begin
                    rt_we    = 1'b1;
                    rt_wdata = '0;
                end
                REQ_TICK: begin
                end
            endcase
        end else if (push_end) begin
            o_push.v0      = 1'b1;
            o_push.e0.kind = EV_END;
            o_push.e0.slot = '0;
            o_push.e0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan      <= '0;
            r_pend      <= 1'b0;
            r_pend_addr <= '0;
            r_pend_twv  <= 1'b0;
            r_pend_rtv  <= 1'b0;
            r_tw_vld    <= '0;
            r_rt_vld    <= '0;
        end else begin
            if (tw_we) begin
                r_tw_vld[wr_addr] <= 1'b1;
            end
            if (rt_we) begin
                r_rt_vld[wr_addr] <= 1'b1;
            end

            r_pend <= issue;
            if (issue) begin
                r_pend_addr <= r_scan;
                r_pend_twv  <= r_tw_vld[r_scan];
                r_pend_rtv  <= r_rt_vld[r_scan];
            end

            unique case (r_state)
                S_IDLE: begin
                    if (req_acc && (i_req == REQ_TICK)) begin
                        r_scan  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (issue) begin
                        if (r_scan == ADDR_W'(NUM_SLOTS - 1)) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_scan <= r_scan + ADDR_W'(1);
                        end
                    end
                end
                S_FLUSH: begin
                    if (push_end) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/tcp_timewait_retrans_timer_table_unit.sv
// Per-socket time-wait and retransmit timer table. Arm and cancel requests are taken
// while no scan runs. A tick request walks all NUM_SLOTS slots through the timer memories,
// one slot per cycle while the eight-entry event queue has room, over the single read port
// with a read-modify-write, then emits an end-of-scan item with tlast set; s_axis_tready
// stays low from the tick until that item is queued. A slot can queue two items while the
// output drains one per cycle when m_axis_tready is high, so the scan waits for room
// whenever items pile up, from many slots expiring in one tick or from m_axis_tready
// stalls; a tick that expires both timers of every slot keeps the input closed while its
// items drain. Release, close and resend items come out in slot order, release before the
// retransmit item of the same slot. No clearing pass is needed after reset.
// depends on ttt_pkg, ttt_ctrl, ttt_evq
module tcp_timewait_retrans_timer_table_unit
    import ttt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_DATA_W-1:0]   s_axis_tdata,   // [3:0] socket_slot, rest zero
    input  logic [1:0]            s_axis_tuser,   // [1:0] req_type

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]   m_axis_tdata,   // [3:0] event_slot, rest zero
    output logic [1:0]            m_axis_tuser,   // [1:0] event_kind
    output logic                  m_axis_tlast
);

    t_cfg                 r_cfg;
    t_evq_push            push;
    logic [EVQ_CNT_W-1:0] evq_count;
    t_event               evq_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tw_ticks  <= TW_TICKS_RST;
            r_cfg.rt_base   <= RT_BASE_RST;
            r_cfg.max_retry <= MAX_RETRY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEWAIT:  r_cfg.tw_ticks  <= i_cfg_wdata[TW_W-1:0];
                CFG_RT_BASE:   r_cfg.rt_base   <= i_cfg_wdata[RT_BASE_W-1:0];
                CFG_MAX_RETRY: r_cfg.max_retry <= i_cfg_wdata[RETRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ttt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (t_req'(s_axis_tuser)),
        .i_slot      (s_axis_tdata[SLOT_W-1:0]),
        .i_evq_count (evq_count),
        .o_push      (push)
    );

    ttt_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_count (evq_count),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_event (evq_out)
    );

    assign m_axis_tdata = {{(M_DATA_W - SLOT_W){1'b0}}, evq_out.slot};
    assign m_axis_tuser = evq_out.kind;
    assign m_axis_tlast = evq_out.last;

endmodule

FILE: bench/timer_table_checker.sv
// checker for the tcp timer table: keeps its own copy of the slot timers and registers,
// predicts the events of every tick scan and compares them with the event stream
// depends on ttt_pkg
module timer_table_checker
    import ttt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,

    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [S_DATA_W-1:0]   i_req_data,   // [3:0] socket_slot
    input  logic [1:0]            i_req_user,   // [1:0] req_type

    input  logic                  i_ev_valid,
    input  logic                  i_ev_ready,
    input  logic [M_DATA_W-1:0]   i_ev_data,    // [3:0] event_slot
    input  logic [1:0]            i_ev_user,    // [1:0] event_kind
    input  logic                  i_ev_last,

    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_scan_count,
    output int                    o_release_count,
    output int                    o_close_count,
    output int                    o_resend_count
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg    timer_cfg;
    t_tw_ent tw_table [NUM_SLOTS];
    t_rt_ent rt_table [NUM_SLOTS];
    t_event  expected_events [$];

    int fails;
    int scans;
    int releases;
    int closes;
    int resends;

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_scan_count    = 0;
        o_release_count = 0;
        o_close_count   = 0;
        o_resend_count  = 0;
        fails    = 0;
        scans    = 0;
        releases = 0;
        closes   = 0;
        resends  = 0;
    end

    function automatic t_event make_event(t_ev_kind kind, int slot, logic last);
        t_event ev;
        ev.kind = kind;
        ev.slot = SLOT_W'(slot);
        ev.last = last;
        return ev;
    endfunction

    // updates the timer copy for one request, queuing the events of a tick scan
    task automatic apply_request(t_req req, logic [SLOT_W-1:0] slot);
        int s;
        if (req != REQ_TICK) begin
            if (int'(slot) >= NUM_SLOTS)
                return;
            case (req)
                REQ_ARM_TW: begin
                    tw_table[slot].act = 1'b1;
                    tw_table[slot].rem = timer_cfg.tw_ticks;
                end
                REQ_ARM_RT: begin
                    rt_table[slot].act     = 1'b1;
                    rt_table[slot].rem     = RT_REM_W'(timer_cfg.rt_base);
                    rt_table[slot].retries = '0;
                end
                default: begin
                    rt_table[slot].act = 1'b0;
                end
            endcase
            return;
        end
        for (s = 0; s < NUM_SLOTS; s++) begin
            // time-wait goes first, so its release precedes the retransmit item
            if (tw_table[s].act) begin
                if (tw_table[s].rem <= 1) begin
                    tw_table[s].rem = '0;
                    tw_table[s].act = 1'b0;
                    expected_events.push_back(make_event(EV_RELEASE, s, 1'b0));
                end else begin
                    tw_table[s].rem = tw_table[s].rem - 1'b1;
                end
            end
            if (rt_table[s].act) begin
                if (rt_table[s].rem <= 1) begin
                    rt_table[s].rem = '0;
                    if (rt_table[s].retries >= timer_cfg.max_retry) begin
                        rt_table[s].act = 1'b0;
                        expected_events.push_back(make_event(EV_CLOSE, s, 1'b0));
                    end else begin
                        rt_table[s].rem = RT_REM_W'(timer_cfg.rt_base) << rt_table[s].retries;
                        rt_table[s].retries = rt_table[s].retries + 1'b1;
                        expected_events.push_back(make_event(EV_RESEND, s, 1'b0));
                    end
                end else begin
                    rt_table[s].rem = rt_table[s].rem - 1'b1;
                end
            end
        end
        expected_events.push_back(make_event(EV_END, 0, 1'b1));
    endtask

    always @(posedge i_clk) begin : monitor
        t_event want;
        int     s;
        if (!i_rst_n) begin
            timer_cfg.tw_ticks  = TW_TICKS_RST;
            timer_cfg.rt_base   = RT_BASE_RST;
            timer_cfg.max_retry = MAX_RETRY_RST;
            for (s = 0; s < NUM_SLOTS; s++) begin
                tw_table[s] = '0;
                rt_table[s] = '0;
            end
            expected_events.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TIMEWAIT:  timer_cfg.tw_ticks  = i_cfg_wdata[TW_W-1:0];
                    CFG_RT_BASE:   timer_cfg.rt_base   = i_cfg_wdata[RT_BASE_W-1:0];
                    CFG_MAX_RETRY: timer_cfg.max_retry = i_cfg_wdata[RETRY_W-1:0];
                    default: ;
                endcase
            end
            if (i_ev_valid && i_ev_ready) begin
                case (i_ev_user)
                    EV_END:     scans++;
                    EV_RELEASE: releases++;
                    EV_CLOSE:   closes++;
                    default:    resends++;
                endcase
                if (expected_events.size() == 0) begin
                    $error("event_kind %0d slot %0d last %0b arrived with nothing expected",
                           i_ev_user, i_ev_data[SLOT_W-1:0], i_ev_last);
                    fails++;
                end else begin
                    want = expected_events.pop_front();
                    if (i_ev_user != want.kind) begin
                        $error("event_kind: expected %0d, got %0d", want.kind, i_ev_user);
                        fails++;
                    end
                    if (i_ev_data[SLOT_W-1:0] != want.slot) begin
                        $error("event_slot: expected %0d, got %0d",
                               want.slot, i_ev_data[SLOT_W-1:0]);
                        fails++;
                    end
                    if (i_ev_last != want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_ev_last);
                        fails++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                apply_request(t_req'(i_req_user), i_req_data[SLOT_W-1:0]);
        end
        o_fail_count    <= fails;
        o_pending       <= expected_events.size();
        o_scan_count    <= scans;
        o_release_count <= releases;
        o_close_count   <= closes;
        o_resend_count  <= resends;
    end

endmodule

FILE: bench/testbench.sv
// top of the timer table bench: clock, reset, register writes and request stimulus
// with phases of random idling; checking is done in timer_table_checker
// depends on ttt_pkg, tcp_timewait_retrans_timer_table_unit, timer_table_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ttt_pkg::*;

    // worst legal gap is one full scan under heavy output stall, far below this
    localparam int IDLE_LIMIT   = 4000;
    localparam int QUIET_CYCLES = 40;
    localparam int PHASE_ITEMS  = 39;
    localparam int RAND_PHASES  = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;   // [3:0] socket_slot, rest zero
    logic [1:0]            s_axis_tuser;   // [1:0] req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;   // [3:0] event_slot, rest zero
    logic [1:0]            m_axis_tuser;   // [1:0] event_kind
    logic                  m_axis_tlast;

    int fail_count;
    int pending;
    int scan_count;
    int release_count;
    int close_count;
    int resend_count;

    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;
    int requests_sent;

    tcp_timewait_retrans_timer_table_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    timer_table_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req_valid     (s_axis_tvalid),
        .i_req_ready     (s_axis_tready),
        .i_req_data      (s_axis_tdata),
        .i_req_user      (s_axis_tuser),
        .i_ev_valid      (m_axis_tvalid),
        .i_ev_ready      (m_axis_tready),
        .i_ev_data       (m_axis_tdata),
        .i_ev_user       (m_axis_tuser),
        .i_ev_last       (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_scan_count    (scan_count),
        .o_release_count (release_count),
        .o_close_count   (close_count),
        .o_resend_count  (resend_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input t_req req, input logic [SLOT_W-1:0] slot);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= S_DATA_W'(slot);
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        requests_sent++;
    endtask

    // sender holds off until every predicted event is out, then lets the block go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [TW_W-1:0] tw, input logic [RT_BASE_W-1:0] base,
                                input logic [RETRY_W-1:0] retries);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_TIMEWAIT;
        i_cfg_wdata <= CFG_DATA_W'(tw);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_RT_BASE;
        i_cfg_wdata <= CFG_DATA_W'(base);
        @(posedge i_clk);
        i_cfg_idx   <= CFG_MAX_RETRY;
        i_cfg_wdata <= CFG_DATA_W'(retries);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 75; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 75; end
            default: begin send_idle_pct = 9; recv_stall_pct <= 9; end
        endcase
    endtask

    initial begin
        t_req req;
        int   pick;
        int   p;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_TIMEWAIT;
        i_cfg_wdata    <= '0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= REQ_TICK;
        m_axis_tready  <= 1'b0;
        recv_stall_pct <= 0;
        send_idle_pct  = 0;
        idle_cycles    = 0;
        requests_sent  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: resends after two ticks, re-arm clears retries, idle cancel
        send_item(REQ_ARM_TW, 4'd0);
        send_item(REQ_ARM_RT, 4'd15);
        send_item(REQ_ARM_RT, 4'd3);
        send_item(REQ_CANCEL_RT, 4'd7);
        send_item(REQ_TICK, 4'd9);
        send_item(REQ_TICK, 4'd0);
        send_item(REQ_CANCEL_RT, 4'd3);
        send_item(REQ_ARM_RT, 4'd15);
        send_item(REQ_TICK, 4'd15);
        send_item(REQ_TICK, 4'd6);
        send_item(REQ_TICK, 4'd0);
        settle();

        // zero timeouts expire at the next tick, zero retry limit closes at once
        write_config('0, '0, '0);
        send_item(REQ_ARM_TW, 4'd5);
        send_item(REQ_ARM_RT, 4'd5);
        send_item(REQ_ARM_RT, 4'd10);
        send_item(REQ_ARM_TW, 4'd15);
        send_item(REQ_TICK, 4'd10);
        send_item(REQ_ARM_RT, 4'd0);
        send_item(REQ_ARM_TW, 4'd0);
        send_item(REQ_TICK, 4'd5);
        send_item(REQ_TICK, 4'd15);
        settle();

        for (p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: write_config('1, '1, 2'd3);
                1: write_config(16'd1, 12'd1, 2'd1);
                default: write_config(TW_W'($urandom_range(8)), RT_BASE_W'($urandom_range(3)),
                                      RETRY_W'($urandom_range(3)));
            endcase
            set_idling(p % 4);
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 35)
                    req = REQ_TICK;
                else if (pick < 55)
                    req = REQ_ARM_TW;
                else if (pick < 85)
                    req = REQ_ARM_RT;
                else
                    req = REQ_CANCEL_RT;
                send_item(req, SLOT_W'($urandom_range(15)));
            end
            settle();
        end

        $display("%0d requests over %0d register settings and four idling patterns",
                 requests_sent, RAND_PHASES + 2);
        $display("%0d scans with %0d releases, %0d closes and %0d resends checked",
                 scan_count, release_count, close_count, resend_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/ttt_pkg.sv
rtl/ttt_ram.sv
rtl/ttt_upd.sv
rtl/ttt_evq.sv
rtl/ttt_ctrl.sv
rtl/tcp_timewait_retrans_timer_table_unit.sv
bench/timer_table_checker.sv
bench/testbench.sv
